// ===== rtl/core/arm_inverse_kinematics_macros.svh =====
// Assertion macros for the arm inverse kinematics checker.
`ifndef ARM_INVERSE_KINEMATICS_MACROS_SVH
`define ARM_INVERSE_KINEMATICS_MACROS_SVH

// Concurrent assertion that is ignored while reset is held.
`define AIK_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("arm inverse kinematics check failed");

// Concurrent assertion that also holds during reset.
`define AIK_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("arm inverse kinematics reset check failed");

`endif

// ===== rtl/core/aik_pkg.sv =====
// Types, constants and a helper function for the arm inverse kinematics block.
package aik_pkg;

    // Address width of the register port and register indexes.
    localparam int ADDR_W = 5;
    localparam logic [2:0] REG_OFFSET_X      = 3'd0;
    localparam logic [2:0] REG_OFFSET_Y      = 3'd1;
    localparam logic [2:0] REG_OFFSET_Z      = 3'd2;
    localparam logic [2:0] REG_BASE_ZERO     = 3'd3;
    localparam logic [2:0] REG_SHOULDER_ZERO = 3'd4;
    localparam logic [2:0] REG_ELBOW_ZERO    = 3'd5;
    localparam logic [2:0] REG_ELBOW_DOWN    = 3'd6;

    // CORDIC widths: operand input, working datapath and angle accumulator.
    localparam int CORDIC_STEPS = 24;
    localparam int CORD_IN_W    = 23;
    localparam int CORD_W       = 46;
    localparam int ANG_W        = 28;
    localparam int SUM_W        = 30;

    // Angles at 2^24 per radian.
    localparam logic signed [ANG_W-1:0] ANG_HALF_PI = 28'sd26353589;
    localparam logic signed [SUM_W-1:0] ANG_PI      = 30'sd52707179;

    localparam logic [25:0] ATAN_TAB [CORDIC_STEPS] = '{
        26'd13176795, 26'd7778716, 26'd4110060, 26'd2086331,
        26'd1047214,  26'd524117,  26'd262123,  26'd131069,
        26'd65536,    26'd32768,   26'd16384,   26'd8192,
        26'd4096,     26'd2048,    26'd1024,    26'd512,
        26'd256,      26'd128,     26'd64,      26'd32,
        26'd16,       26'd8,       26'd4,       26'd2
    };

    typedef struct packed {
        logic signed [19:0] target_x;
        logic signed [19:0] target_y;
        logic signed [19:0] target_z;
    } aik_in_t;

    typedef struct packed {
        logic signed [19:0] base_angle;
        logic signed [19:0] shoulder_angle;
        logic signed [19:0] elbow_angle;
        logic               reach_clamped;
    } aik_out_t;

    // Round an internal angle to 65536 per radian, remove the zero and saturate.
    function automatic logic signed [19:0] angle_out(
        input logic signed [SUM_W-1:0] ang,
        input logic signed [19:0]      zero
    );
        logic signed [SUM_W-1:0] rnd;
        logic signed [22:0]      val;
        rnd = ang + 30'sd128;
        val = 23'(rnd >>> 8) - 23'(zero);
        if (val < -23'sd524288) begin
            return -20'sd524288;
        end else if (val > 23'sd524287) begin
            return 20'sd524287;
        end
        return 20'(val);
    endfunction

endpackage

// ===== rtl/core/aik_delay.sv =====
// Enabled shift line that keeps side data aligned with the pipelined units.
module aik_delay #(
    parameter int W     = 8,
    parameter int DEPTH = 2
) (
    input  logic         aclk,
    input  logic         en,
    input  logic [W-1:0] din,
    output logic [W-1:0] dout
);

    logic [W-1:0] line_reg [DEPTH];

    // Shift one place whenever the pipeline advances.
    always_ff @(posedge aclk) begin
        if (en) begin
            line_reg[0] <= din;
            for (int i = 1; i < DEPTH; i++) begin
                line_reg[i] <= line_reg[i-1];
            end
        end
    end

    assign dout = line_reg[DEPTH-1];

endmodule

// ===== rtl/core/aik_isqrt.sv =====
// Pipelined floor integer square root, one result bit per stage.
module aik_isqrt #(
    parameter int W = 21
) (
    input  logic           aclk,
    input  logic           en,
    input  logic [2*W-1:0] rad,
    output logic [W-1:0]   root
);

    logic [2*W-1:0] rad_reg  [W];
    logic [W+1:0]   rem_reg  [W];
    logic [W-1:0]   root_reg [W];

    genvar k;
    generate
        for (k = 0; k < W; k++) begin : g_stage
            logic [2*W-1:0] rad_in;
            logic [W+1:0]   rem_in;
            logic [W-1:0]   root_in;
            logic [W+1:0]   rem_sh;
            logic [W+1:0]   trial;

            if (k == 0) begin : g_first
                assign rad_in  = rad;
                assign rem_in  = '0;
                assign root_in = '0;
            end else begin : g_rest
                assign rad_in  = rad_reg[k-1];
                assign rem_in  = rem_reg[k-1];
                assign root_in = root_reg[k-1];
            end

            // Bring down the next two radicand bits and try the next root bit.
            assign rem_sh = {rem_in[W-1:0], rad_in[2*W-1 -: 2]};
            assign trial  = {root_in, 2'b01};

            always_ff @(posedge aclk) begin
                if (en) begin
                    rad_reg[k] <= {rad_in[2*W-3:0], 2'b00};
                    if (rem_sh >= trial) begin
                        rem_reg[k]  <= rem_sh - trial;
                        root_reg[k] <= {root_in[W-2:0], 1'b1};
                    end else begin
                        rem_reg[k]  <= rem_sh;
                        root_reg[k] <= {root_in[W-2:0], 1'b0};
                    end
                end
            end
        end
    endgenerate

    assign root = root_reg[W-1];

endmodule

// ===== rtl/core/aik_cordic.sv =====
// Pipelined CORDIC vectoring unit computing atan2(y, x) at 2^24 per radian.
module aik_cordic
    import aik_pkg::*;
(
    input  logic                        aclk,
    input  logic                        en,
    input  logic signed [CORD_IN_W-1:0] y_in,
    input  logic signed [CORD_IN_W-1:0] x_in,
    output logic signed [ANG_W-1:0]     z_out
);

    logic signed [CORD_W-1:0] x_reg    [CORDIC_STEPS+1];
    logic signed [CORD_W-1:0] y_reg    [CORDIC_STEPS+1];
    logic signed [ANG_W-1:0]  z_reg    [CORDIC_STEPS+1];
    logic                     zero_reg [CORDIC_STEPS+1];

    logic signed [CORD_IN_W-1:0] x_rot;
    logic signed [CORD_IN_W-1:0] y_rot;
    logic signed [ANG_W-1:0]     z_rot;

    // Move the left half plane into the right one by a quarter turn.
    always_comb begin
        x_rot = x_in;
        y_rot = y_in;
        z_rot = '0;
        if (x_in < 0) begin
            if (y_in >= 0) begin
                x_rot = y_in;
                y_rot = -x_in;
                z_rot = ANG_HALF_PI;
            end else begin
                x_rot = -y_in;
                y_rot = x_in;
                z_rot = -ANG_HALF_PI;
            end
        end
    end

    // Prescale stage; the origin is flagged and reads as angle zero.
    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg[0]    <= {{3{x_rot[CORD_IN_W-1]}}, x_rot, 20'd0};
            y_reg[0]    <= {{3{y_rot[CORD_IN_W-1]}}, y_rot, 20'd0};
            z_reg[0]    <= z_rot;
            zero_reg[0] <= (x_in == '0) && (y_in == '0);
        end
    end

    genvar k;
    generate
        for (k = 0; k < CORDIC_STEPS; k++) begin : g_step
            logic y_pos;
            assign y_pos = !y_reg[k][CORD_W-1] && (y_reg[k] != '0);

            // One micro-rotation toward the x axis.
            always_ff @(posedge aclk) begin
                if (en) begin
                    zero_reg[k+1] <= zero_reg[k];
                    if (y_pos) begin
                        x_reg[k+1] <= x_reg[k] + (y_reg[k] >>> k);
                        y_reg[k+1] <= y_reg[k] - (x_reg[k] >>> k);
                        z_reg[k+1] <= z_reg[k] + signed'({2'b00, ATAN_TAB[k]});
                    end else begin
                        x_reg[k+1] <= x_reg[k] - (y_reg[k] >>> k);
                        y_reg[k+1] <= y_reg[k] + (x_reg[k] >>> k);
                        z_reg[k+1] <= z_reg[k] - signed'({2'b00, ATAN_TAB[k]});
                    end
                end
            end
        end
    endgenerate

    assign z_out = zero_reg[CORDIC_STEPS] ? '0 : z_reg[CORDIC_STEPS];

endmodule

// ===== rtl/core/arm_inverse_kinematics.sv =====
// Throughput: one word per cycle; the whole pipeline advances together and holds
// while a finished result waits on m_ready, so the square root and CORDIC stages
// set the depth but never the rate. Reset (aresetn low, synchronous) empties the
// pipeline and clears all configuration registers to zero.
module arm_inverse_kinematics
    import aik_pkg::*;
#(
    parameter int BASE_HEIGHT  = 25600,
    parameter int UPPER_LINK   = 30720,
    parameter int LOWER_LINK   = 30720,
    parameter int TOOL_FORWARD = 12800,
    parameter int TOOL_DOWN    = 12800
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  aik_in_t           s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output aik_out_t          m_data,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    localparam int LAT     = 98;
    localparam int ZW_ADJ  = TOOL_DOWN - BASE_HEIGHT;
    localparam int LINK_LO = (UPPER_LINK > LOWER_LINK) ? UPPER_LINK - LOWER_LINK
                                                        : LOWER_LINK - UPPER_LINK;
    localparam int LINK_HI = UPPER_LINK + LOWER_LINK;
    localparam longint SQ_LO = longint'(LINK_LO) * longint'(LINK_LO);
    localparam longint SQ_HI = longint'(LINK_HI) * longint'(LINK_HI);

    // Configuration registers.
    logic signed [19:0] off_x_reg, off_y_reg, off_z_reg;
    logic signed [19:0] base_zero_reg, shoulder_zero_reg, elbow_zero_reg;
    logic               elbow_down_reg;
    logic [2:0]         reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[ADDR_W-1:2];

    // Register writes on the access phase.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            off_x_reg         <= '0;
            off_y_reg         <= '0;
            off_z_reg         <= '0;
            base_zero_reg     <= '0;
            shoulder_zero_reg <= '0;
            elbow_zero_reg    <= '0;
            elbow_down_reg    <= 1'b0;
        end else if (psel && penable && pwrite && pready) begin
            case (reg_idx)
                REG_OFFSET_X:      off_x_reg         <= pwdata[19:0];
                REG_OFFSET_Y:      off_y_reg         <= pwdata[19:0];
                REG_OFFSET_Z:      off_z_reg         <= pwdata[19:0];
                REG_BASE_ZERO:     base_zero_reg     <= pwdata[19:0];
                REG_SHOULDER_ZERO: shoulder_zero_reg <= pwdata[19:0];
                REG_ELBOW_ZERO:    elbow_zero_reg    <= pwdata[19:0];
                REG_ELBOW_DOWN:    elbow_down_reg    <= pwdata[0];
                default: ;
            endcase
        end
    end

    // Register reads, sign extended to the bus width.
    always_comb begin
        case (reg_idx)
            REG_OFFSET_X:      prdata = 32'(off_x_reg);
            REG_OFFSET_Y:      prdata = 32'(off_y_reg);
            REG_OFFSET_Z:      prdata = 32'(off_z_reg);
            REG_BASE_ZERO:     prdata = 32'(base_zero_reg);
            REG_SHOULDER_ZERO: prdata = 32'(shoulder_zero_reg);
            REG_ELBOW_ZERO:    prdata = 32'(elbow_zero_reg);
            REG_ELBOW_DOWN:    prdata = {31'd0, elbow_down_reg};
            default:           prdata = '0;
        endcase
    end

    // Pipeline control: every stage moves unless the output word is stalled.
    logic           adv;
    logic [LAT-1:0] vld_reg;

    assign adv     = !vld_reg[LAT-1] || m_ready;
    assign s_ready = adv;
    assign m_valid = vld_reg[LAT-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[LAT-2:0], s_valid};
        end
    end

    // Stage 1: remove the Cartesian offsets.
    logic signed [20:0] xi_reg, yi_reg, zi_reg;
    always_ff @(posedge aclk) begin
        if (adv) begin
            xi_reg <= 21'(s_data.target_x) - 21'(off_x_reg);
            yi_reg <= 21'(s_data.target_y) - 21'(off_y_reg);
            zi_reg <= 21'(s_data.target_z) - 21'(off_z_reg);
        end
    end

    // Stage 2: squares of the horizontal components and the wrist height.
    logic [41:0]        xx_reg, yy_reg;
    logic signed [21:0] zw_reg;
    logic signed [41:0] xx_full, yy_full;
    assign xx_full = xi_reg * xi_reg;
    assign yy_full = yi_reg * yi_reg;
    always_ff @(posedge aclk) begin
        if (adv) begin
            xx_reg <= xx_full;
            yy_reg <= yy_full;
            zw_reg <= 22'(zi_reg) + 22'(ZW_ADJ);
        end
    end

    // Horizontal radius of the target.
    logic [20:0] rad_xy;
    logic [41:0] sum_xy;
    assign sum_xy = xx_reg + yy_reg;
    aik_isqrt #(.W(21)) u_sqrt_xy (.aclk(aclk), .en(adv), .rad(sum_xy), .root(rad_xy));

    logic [21:0] zw_d1;
    aik_delay #(.W(22), .DEPTH(21)) u_dly_zw (
        .aclk(aclk), .en(adv), .din(zw_reg), .dout(zw_d1)
    );

    // Stage 24: wrist radius with the tool reach removed, floored at zero.
    logic [20:0]        rw_reg;
    logic signed [21:0] zw2_reg;
    logic signed [22:0] rw_diff;
    assign rw_diff = signed'({2'b00, rad_xy}) - 23'(TOOL_FORWARD);
    always_ff @(posedge aclk) begin
        if (adv) begin
            rw_reg  <= rw_diff[22] ? '0 : rw_diff[20:0];
            zw2_reg <= zw_d1;
        end
    end

    // Stage 25: squares for the shoulder-to-wrist distance.
    logic [43:0]        rr_reg;
    logic signed [43:0] zz_reg;
    logic [41:0]        rr_full;
    assign rr_full = rw_reg * rw_reg;
    always_ff @(posedge aclk) begin
        if (adv) begin
            rr_reg <= {2'b00, rr_full};
            zz_reg <= zw2_reg * zw2_reg;
        end
    end

    logic [21:0] d_raw;
    logic [43:0] sum_rz;
    assign sum_rz = rr_reg + zz_reg;
    aik_isqrt #(.W(22)) u_sqrt_d (.aclk(aclk), .en(adv), .rad(sum_rz), .root(d_raw));

    // Stage 48: clamp the distance to the reachable band.
    logic [19:0] d_reg;
    logic        clamp_reg;
    always_ff @(posedge aclk) begin
        if (adv) begin
            if (d_raw < 22'(LINK_LO)) begin
                d_reg     <= (LINK_LO < 1) ? 20'd1 : 20'(LINK_LO);
                clamp_reg <= 1'b1;
            end else if (d_raw > 22'(LINK_HI)) begin
                d_reg     <= 20'(LINK_HI);
                clamp_reg <= 1'b1;
            end else begin
                d_reg     <= (d_raw == '0) ? 20'd1 : d_raw[19:0];
                clamp_reg <= 1'b0;
            end
        end
    end

    // Stage 49: law of cosines products.
    logic [39:0]        dd_reg;
    logic signed [43:0] pf_reg, qf_reg;
    logic signed [21:0] fp_a, fp_b, fq_a, fq_b;
    assign fp_a = signed'({2'b00, d_reg}) + 22'(LOWER_LINK - UPPER_LINK);
    assign fp_b = 22'(LINK_HI) - signed'({2'b00, d_reg});
    assign fq_a = signed'({2'b00, d_reg}) + 22'(UPPER_LINK - LOWER_LINK);
    assign fq_b = signed'({2'b00, d_reg}) + 22'(LINK_HI);
    always_ff @(posedge aclk) begin
        if (adv) begin
            dd_reg <= d_reg * d_reg;
            pf_reg <= fp_a * fp_b;
            qf_reg <= fq_a * fq_b;
        end
    end

    // Stage 50: square root operands, negatives taken as zero.
    logic [41:0]        a_reg, b_reg, p_reg, q_reg;
    logic signed [43:0] a_full, b_full;
    assign a_full = signed'({4'd0, dd_reg}) - 44'(SQ_LO);
    assign b_full = 44'(SQ_HI) - signed'({4'd0, dd_reg});
    always_ff @(posedge aclk) begin
        if (adv) begin
            a_reg <= a_full[43] ? '0 : a_full[41:0];
            b_reg <= b_full[43] ? '0 : b_full[41:0];
            p_reg <= pf_reg[43] ? '0 : pf_reg[41:0];
            q_reg <= qf_reg[43] ? '0 : qf_reg[41:0];
        end
    end

    logic [20:0] sa, sb, sp, sq;
    aik_isqrt #(.W(21)) u_sqrt_a (.aclk(aclk), .en(adv), .rad(a_reg), .root(sa));
    aik_isqrt #(.W(21)) u_sqrt_b (.aclk(aclk), .en(adv), .rad(b_reg), .root(sb));
    aik_isqrt #(.W(21)) u_sqrt_p (.aclk(aclk), .en(adv), .rad(p_reg), .root(sp));
    aik_isqrt #(.W(21)) u_sqrt_q (.aclk(aclk), .en(adv), .rad(q_reg), .root(sq));

    // Side data brought up to the CORDIC inputs.
    logic [42:0] rz_d;
    logic [41:0] xy_d;
    logic [0:0]  clamp_d;
    aik_delay #(.W(43), .DEPTH(47)) u_dly_rz (
        .aclk(aclk), .en(adv), .din({rw_reg, zw2_reg}), .dout(rz_d)
    );
    aik_delay #(.W(42), .DEPTH(70)) u_dly_xy (
        .aclk(aclk), .en(adv), .din({xi_reg, yi_reg}), .dout(xy_d)
    );
    aik_delay #(.W(1), .DEPTH(48)) u_dly_clamp (
        .aclk(aclk), .en(adv), .din(clamp_reg), .dout(clamp_d)
    );

    // Four angle units in parallel.
    logic signed [ANG_W-1:0] alpha_z, phi_z, beta_z, base_z;
    aik_cordic u_cordic_alpha (
        .aclk(aclk), .en(adv),
        .y_in(23'(signed'(rz_d[21:0]))), .x_in({2'b00, rz_d[42:22]}),
        .z_out(alpha_z)
    );
    aik_cordic u_cordic_phi (
        .aclk(aclk), .en(adv), .y_in({2'b00, sa}), .x_in({2'b00, sb}), .z_out(phi_z)
    );
    aik_cordic u_cordic_beta (
        .aclk(aclk), .en(adv), .y_in({2'b00, sp}), .x_in({2'b00, sq}), .z_out(beta_z)
    );
    aik_cordic u_cordic_base (
        .aclk(aclk), .en(adv),
        .y_in(23'(signed'(xy_d[20:0]))), .x_in(23'(signed'(xy_d[41:21]))),
        .z_out(base_z)
    );

    // Stage 97: joint angles for the selected elbow solution.
    logic signed [SUM_W-1:0] sh_reg, el_reg, base_reg;
    logic                    clamp2_reg;
    logic signed [SUM_W-1:0] phi2, beta2;
    assign phi2  = SUM_W'(phi_z) <<< 1;
    assign beta2 = SUM_W'(beta_z) <<< 1;
    always_ff @(posedge aclk) begin
        if (adv) begin
            base_reg   <= SUM_W'(base_z);
            clamp2_reg <= clamp_d[0];
            if (elbow_down_reg) begin
                sh_reg <= SUM_W'(alpha_z) - beta2;
                el_reg <= phi2 - ANG_PI;
            end else begin
                sh_reg <= SUM_W'(alpha_z) + beta2;
                el_reg <= ANG_PI - phi2;
            end
        end
    end

    // Stage 98: output word, rounded, zeroed and saturated.
    aik_out_t out_reg;
    always_ff @(posedge aclk) begin
        if (adv) begin
            out_reg.base_angle     <= angle_out(base_reg, base_zero_reg);
            out_reg.shoulder_angle <= angle_out(sh_reg, shoulder_zero_reg);
            out_reg.elbow_angle    <= angle_out(el_reg, elbow_zero_reg);
            out_reg.reach_clamped  <= clamp2_reg;
        end
    end

    assign m_data = out_reg;

endmodule

// ===== rtl/core/aik_checker.sv =====
// Port-level checker for the arm inverse kinematics block and its bind.
`include "arm_inverse_kinematics_macros.svh"

module aik_checker
    import aik_pkg::*;
(
    input logic     aclk,
    input logic     aresetn,
    input logic     s_valid,
    input logic     s_ready,
    input logic     m_valid,
    input logic     m_ready,
    input aik_out_t m_data
);

    // The pipeline is empty in the cycle after reset.
    `AIK_ASSERT_ALWAYS(a_reset_empty, aclk, !aresetn |=> !m_valid)

    // A stalled result word holds its value.
    `AIK_ASSERT(a_out_hold, aclk, aresetn, m_valid && !m_ready |=> m_valid && $stable(m_data))

    // An empty output stage never blocks the input.
    `AIK_ASSERT(a_ready_free, aclk, aresetn, !m_valid |-> s_ready)

    // A stalled output freezes the whole pipeline, so no word is taken.
    `AIK_ASSERT(a_stall_blocks, aclk, aresetn, m_valid && !m_ready |-> !s_ready)

endmodule

bind arm_inverse_kinematics aik_checker u_aik_checker (.*);
